FILE: sv/uade_pkg.sv
package uade_pkg;

  localparam int DIGIT_W         = 31;
  localparam int BASE_W          = 31;
  localparam int CHUNK_W         = 52;
  localparam int KIND_W          = 2;
  localparam int SMALL_SHIFT     = 8;
  localparam int SMALL_BASE_BITS = 5;

  localparam logic [KIND_W-1:0] KIND_SMALL_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LARGE_WORD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SMALL_FINAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LARGE_FINAL = 2'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [BASE_W-1:0]  base;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [KIND_W-1:0]  kind;
    logic               final_res;
  } out_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [BASE_W-1:0]  base;
    logic               last;
    logic               use_small;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } q_head_t;

endpackage

FILE: sv/uade_stream_if.sv
interface uade_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/uade_front.sv
module uade_front (
  input  logic              clk,
  input  logic              rst,
  uade_stream_if.sink       symbols,
  output uade_pkg::q_head_t head,
  input  logic              pop
);
  import uade_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  qent_t          q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  qent_t          ent_in;

  assign symbols.ready = (count != (QAW+1)'(QDEPTH));
  assign push          = symbols.valid && symbols.ready;

  // classify: bases below 32 go to the small coder
  always_comb begin
    ent_in.digit     = symbols.data.digit;
    ent_in.base      = symbols.data.base;
    ent_in.last      = symbols.data.last;
    ent_in.use_small = (symbols.data.base[BASE_W-1:SMALL_BASE_BITS] == '0);
  end

  assign head.valid = (count != '0);
  assign head.ent   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= ent_in;
        wr_ptr        <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/uade_back.sv
module uade_back #(
  parameter int SMALL_STATE_BITS = 23,
  parameter int LARGE_STATE_BITS = 52,
  parameter int LARGE_SHIFT      = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  uade_pkg::q_head_t head,
  output logic              pop,
  uade_stream_if.source     chunks
);
  import uade_pkg::*;

  localparam int S   = SMALL_STATE_BITS;
  localparam int L   = LARGE_STATE_BITS;
  localparam int K   = LARGE_SHIFT;
  localparam int SPW = S + SMALL_BASE_BITS;
  localparam int LH  = (L + 1) / 2;
  localparam int HW  = L - LH;
  localparam int PLW = LH + BASE_W;
  localparam int PHW = HW + BASE_W;
  localparam int RW  = K + BASE_W;
  localparam int FW  = L + BASE_W;

  localparam logic [S-1:0] SMALL_INIT = S'(1) << (S - SMALL_SHIFT);
  localparam logic [L-1:0] LARGE_INIT = L'(1) << (L - K);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         st;
  logic [S-1:0]       small_state;
  logic [L-1:0]       large_state;
  logic [DIGIT_W-1:0] cur_digit;
  logic               cur_last;
  logic               cur_small;

  logic [SPW-1:0]     sp;
  logic [SPW-1:0]     sq;
  logic [PLW-1:0]     p_lo;
  logic [PHW-1:0]     p_hi;
  logic [RW-1:0]      r;
  logic [FW-1:0]      full;

  logic [2:0]         emit_mask;
  logic [CHUNK_W-1:0] ren_chunk;
  logic [KIND_W-1:0]  ren_kind;
  logic [S-1:0]       fin_small;
  logic [L-1:0]       fin_large;

  logic               out_valid;
  out_item_t          out_data;

  logic               ovf_s;
  logic               ovf_l;
  logic               ovf;
  logic [SPW-1:0]     sel_s;
  logic [S-1:0]       new_s;
  logic [FW-1:0]      alt;
  logic [L-1:0]       sel_l;
  logic [L-1:0]       new_l;
  logic [S-1:0]       nxt_small;
  logic [L-1:0]       nxt_large;

  logic               load;
  out_item_t          emit_item;
  logic [2:0]         emit_rest;

  assign pop = (st == ST_IDLE) && head.valid;

  // state update: pick the renormalized product when the state overflows
  always_comb begin
    ovf_s = (sp[SPW-1:S] != '0);
    sel_s = ovf_s ? sq : sp;
    new_s = sel_s[S-1:0] + cur_digit[S-1:0];

    ovf_l = (full[FW-1:L] != '0);
    // (s >> K) * b equals (s*b - (s mod 2^K)*b) >> K
    alt   = (full - FW'(r)) >> K;
    sel_l = ovf_l ? alt[L-1:0] : full[L-1:0];
    new_l = sel_l + L'(cur_digit);

    ovf       = cur_small ? ovf_s : ovf_l;
    nxt_small = cur_small ? new_s : small_state;
    nxt_large = cur_small ? large_state : new_l;
  end

  // emit pending results lowest bit first: renorm chunk, small flush, large flush
  always_comb begin
    if (emit_mask[0]) begin
      emit_item.chunk = ren_chunk;
      emit_item.kind  = ren_kind;
      emit_rest       = emit_mask & 3'b110;
    end else if (emit_mask[1]) begin
      emit_item.chunk = CHUNK_W'(fin_small);
      emit_item.kind  = KIND_SMALL_FINAL;
      emit_rest       = emit_mask & 3'b100;
    end else begin
      emit_item.chunk = CHUNK_W'(fin_large);
      emit_item.kind  = KIND_LARGE_FINAL;
      emit_rest       = 3'b000;
    end
    emit_item.final_res = (emit_rest == 3'b000);
  end

  assign load = (st == ST_EMIT) && (!out_valid || chunks.ready);

  assign chunks.valid = out_valid;
  assign chunks.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      small_state <= SMALL_INIT;
      large_state <= LARGE_INIT;
      emit_mask   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= emit_item;
      end else if (chunks.ready) begin
        out_valid <= 1'b0;
      end

      case (st)
        ST_IDLE: begin
          if (head.valid) begin
            cur_digit <= head.ent.digit;
            cur_last  <= head.ent.last;
            cur_small <= head.ent.use_small;
            sp   <= SPW'(small_state) * SPW'(head.ent.base[SMALL_BASE_BITS-1:0]);
            sq   <= SPW'(small_state >> SMALL_SHIFT)
                    * SPW'(head.ent.base[SMALL_BASE_BITS-1:0]);
            p_lo <= PLW'(large_state[LH-1:0]) * PLW'(head.ent.base);
            p_hi <= PHW'(large_state[L-1:LH]) * PHW'(head.ent.base);
            r    <= RW'(large_state[K-1:0]) * RW'(head.ent.base);
            st   <= head.ent.use_small ? ST_UPD : ST_SUM;
          end
        end
        ST_SUM: begin
          full <= (FW'(p_hi) << LH) + FW'(p_lo);
          st   <= ST_UPD;
        end
        ST_UPD: begin
          emit_mask <= {cur_last, cur_last, ovf};
          ren_chunk <= cur_small ? CHUNK_W'(small_state[SMALL_SHIFT-1:0])
                                 : CHUNK_W'(large_state[K-1:0]);
          ren_kind  <= cur_small ? KIND_SMALL_BYTE : KIND_LARGE_WORD;
          fin_small <= nxt_small;
          fin_large <= nxt_large;
          if (cur_last) begin
            small_state <= SMALL_INIT;
            large_state <= LARGE_INIT;
          end else begin
            small_state <= nxt_small;
            large_state <= nxt_large;
          end
          st <= (cur_last || ovf) ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (load) begin
            emit_mask <= emit_rest;
            if (emit_rest == 3'b000) begin
              st <= ST_IDLE;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    st == ST_EMIT |-> emit_mask != 3'b000)
    else $error("emit state entered with nothing pending");

  a_sum_large_only: assert property (@(posedge clk) disable iff (rst)
    st == ST_SUM |-> !cur_small)
    else $error("small item routed through partial-product sum");

  a_flush_restarts: assert property (@(posedge clk) disable iff (rst)
    (st == ST_UPD && cur_last) |=>
      (small_state == SMALL_INIT && large_state == LARGE_INIT))
    else $error("coder states not restarted after flush");

  a_large_final_closes: assert property (@(posedge clk) disable iff (rst)
    (load && emit_item.kind == KIND_LARGE_FINAL) |-> emit_item.final_res)
    else $error("large flush not marked as final result");
`endif

endmodule

FILE: sv/uniform_ans_dual_state_encoder_unit.sv
// Mixed-radix rANS encoder with a 23-bit small state (bases below 32) and a
// 52-bit large state (larger bases). Symbols enter a two-entry queue that
// accepts while it has room; the coder behind it takes one symbol at a time.
// A small-base symbol passes a multiply and an update, a large-base symbol a
// split 52x31 multiply into partial products, a sum and an update; each
// chunk then takes an emit step, held while a full output register stalls.
// Each result leaves through an output register, so a stalled consumer does
// not stop the queue from filling. Chunks come out in encode order; the
// decoder reads them in reverse. After a symbol marked last, the small then
// the large state are flushed and both states restart.
module uniform_ans_dual_state_encoder_unit #(
  parameter int SMALL_STATE_BITS = 23,
  parameter int LARGE_STATE_BITS = 52,
  parameter int LARGE_SHIFT      = 32
) (
  input  logic          clk,
  input  logic          rst,
  uade_stream_if.sink   symbols,
  uade_stream_if.source chunks
);
  import uade_pkg::*;

  q_head_t head;
  logic    pop;

  uade_front u_front (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .head    (head),
    .pop     (pop)
  );

  uade_back #(
    .SMALL_STATE_BITS (SMALL_STATE_BITS),
    .LARGE_STATE_BITS (LARGE_STATE_BITS),
    .LARGE_SHIFT      (LARGE_SHIFT)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .chunks (chunks)
  );

endmodule
